// ===== hdl/delta_list_timer_queue_unit_assert.svh =====
// Assertion macros for the timer queue controller.
`ifndef DELTA_LIST_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_UNIT_ASSERT_SVH

// Checks that a condition implies a property in the next cycle.
`define DLTQ_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

// Checks that a condition always holds.
`define DLTQ_ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`endif

// ===== hdl/dltq_pkg.sv =====
package dltq_pkg;

	localparam int unsigned SLOTS = 16;
	localparam int unsigned SW = 4;
	localparam int unsigned LW = 5;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam int unsigned MAX_FIRE = 16;

	localparam logic [1:0] OP_REG = 2'd0;
	localparam logic [1:0] OP_REM = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] RK_REG = 2'd0;
	localparam logic [1:0] RK_REM = 2'd1;
	localparam logic [1:0] RK_NF = 2'd2;
	localparam logic [1:0] RK_FIRE = 2'd3;

	// Datapath commands issued by the controller.
	typedef enum logic [3:0] {
		DC_NOP,
		DC_LOAD,
		DC_WALK_INIT,
		DC_WALK_STEP,
		DC_UNLINK,
		DC_SET_PERIOD,
		DC_CLR_PERIOD,
		DC_INS_INIT,
		DC_INS_STEP,
		DC_INS_PLACE,
		DC_TICK_DEC,
		DC_POP,
		DC_REINS_INIT
	} dcmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic slot_listed;
		logic walk_hit;
		logic walk_end;
		logic ins_here;
		logic head_due;
		logic head_nil;
		logic pop_periodic;
		logic [SW-1:0] pop_slot;
	} dstat_t;

endpackage

// ===== hdl/dltq_datapath.sv =====
module dltq_datapath (
	input  logic clk,
	input  logic arst_n,
	input  dltq_pkg::dcmd_t cmd,
	input  logic [dltq_pkg::SW-1:0] in_slot,
	input  logic [31:0] in_time,
	input  logic in_periodic,
	output dltq_pkg::dstat_t stat
);

	logic [31:0] delta_q [dltq_pkg::SLOTS];
	logic [31:0] period_q [dltq_pkg::SLOTS];
	logic [dltq_pkg::LW-1:0] link_q [dltq_pkg::SLOTS];
	logic [dltq_pkg::SLOTS-1:0] listed_q;
	logic [dltq_pkg::LW-1:0] head_q;

	logic [dltq_pkg::SW-1:0] slot_q;
	logic [31:0] time_q;
	logic per_q;
	logic [dltq_pkg::LW-1:0] cur_q;
	logic [dltq_pkg::LW-1:0] prev_q;
	logic [32:0] total_q;

	logic [dltq_pkg::SW-1:0] cur_idx;
	logic [dltq_pkg::SW-1:0] prev_idx;
	logic [dltq_pkg::SW-1:0] head_idx;
	logic [32:0] total_next;
	logic [dltq_pkg::LW-1:0] nx;

	assign cur_idx = cur_q[dltq_pkg::SW-1:0];
	assign prev_idx = prev_q[dltq_pkg::SW-1:0];
	assign head_idx = head_q[dltq_pkg::SW-1:0];
	assign total_next = total_q + {1'b0, delta_q[cur_idx]};
	assign nx = link_q[cur_idx];

	// Status decode for the controller.
	always_comb begin
		stat.slot_listed = listed_q[slot_q];
		stat.walk_end = (cur_q == dltq_pkg::NIL);
		stat.walk_hit = !stat.walk_end && (cur_idx == slot_q);
		stat.ins_here = !stat.walk_end && ({1'b0, time_q} < total_next);
		stat.head_nil = (head_q == dltq_pkg::NIL);
		stat.head_due = !stat.head_nil && (delta_q[head_idx] == 32'd0);
		stat.pop_periodic = (period_q[head_idx] != 32'd0);
		stat.pop_slot = head_idx;
	end

	// Control-side registers of the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			head_q <= dltq_pkg::NIL;
			for (int i = 0; i < dltq_pkg::SLOTS; i++) period_q[i] <= '0;
		end else begin
			case (cmd)
				dltq_pkg::DC_UNLINK: begin
					listed_q[slot_q] <= 1'b0;
					if (prev_q == dltq_pkg::NIL) head_q <= nx;
				end
				dltq_pkg::DC_SET_PERIOD: begin
					period_q[slot_q] <= per_q ? time_q : 32'd0;
				end
				dltq_pkg::DC_CLR_PERIOD: begin
					period_q[slot_q] <= 32'd0;
				end
				dltq_pkg::DC_INS_PLACE: begin
					listed_q[slot_q] <= 1'b1;
					if (prev_q == dltq_pkg::NIL) head_q <= {1'b0, slot_q};
				end
				dltq_pkg::DC_POP: begin
					listed_q[head_idx] <= 1'b0;
					head_q <= link_q[head_idx];
				end
				default: ;
			endcase
		end
	end

	// Payload registers: deltas, links and walk state.
	always_ff @(posedge clk) begin
		case (cmd)
			dltq_pkg::DC_LOAD: begin
				slot_q <= in_slot;
				time_q <= in_time;
				per_q <= in_periodic;
			end
			dltq_pkg::DC_WALK_INIT: begin
				cur_q <= head_q;
				prev_q <= dltq_pkg::NIL;
			end
			dltq_pkg::DC_WALK_STEP: begin
				prev_q <= cur_q;
				cur_q <= nx;
			end
			dltq_pkg::DC_UNLINK: begin
				if (prev_q != dltq_pkg::NIL) link_q[prev_idx] <= nx;
				if (nx != dltq_pkg::NIL)
					delta_q[nx[dltq_pkg::SW-1:0]] <= delta_q[nx[dltq_pkg::SW-1:0]]
						+ delta_q[cur_idx];
			end
			dltq_pkg::DC_INS_INIT: begin
				if (time_q == 32'd0) time_q <= 32'd1;
				cur_q <= head_q;
				prev_q <= dltq_pkg::NIL;
				total_q <= '0;
			end
			dltq_pkg::DC_REINS_INIT: begin
				slot_q <= head_idx;
				time_q <= period_q[head_idx];
				cur_q <= link_q[head_idx];
				prev_q <= dltq_pkg::NIL;
				total_q <= '0;
			end
			dltq_pkg::DC_INS_STEP: begin
				total_q <= total_next;
				prev_q <= cur_q;
				cur_q <= nx;
			end
			dltq_pkg::DC_INS_PLACE: begin
				link_q[slot_q] <= cur_q;
				if (prev_q != dltq_pkg::NIL) link_q[prev_idx] <= {1'b0, slot_q};
				if (cur_q == dltq_pkg::NIL) begin
					delta_q[slot_q] <= 32'({1'b0, time_q} - total_q);
				end else begin
					delta_q[slot_q] <= 32'({1'b0, time_q} - total_q);
					delta_q[cur_idx] <= 32'(total_next - {1'b0, time_q});
				end
			end
			dltq_pkg::DC_TICK_DEC: begin
				if (head_q != dltq_pkg::NIL && delta_q[head_idx] != 32'd0)
					delta_q[head_idx] <= delta_q[head_idx] - 32'd1;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/dltq_ctrl.sv =====
`include "delta_list_timer_queue_unit_assert.svh"

module dltq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] operation,
	input  logic [dltq_pkg::SW-1:0] slot,
	input  dltq_pkg::dstat_t stat,
	output dltq_pkg::dcmd_t cmd,
	output logic busy,
	output logic result_valid,
	output logic [1:0] result_kind,
	output logic [dltq_pkg::SW-1:0] result_slot,
	output logic last,
	output logic queue_nonempty
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_RM_WALK, S_RG_WALK, S_RG_PER, S_RG_INIT, S_INS,
		S_TK_CHECK, S_TK_POP, S_TK_REINS, S_TK_EMIT, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [1:0] kind_q;
	logic [dltq_pkg::SW-1:0] rslot_q;
	logic [4:0] fired_q;
	logic [4:0] emit_q;
	logic [dltq_pkg::SW-1:0] fire_slot_q [dltq_pkg::MAX_FIRE];

	// Command decode from state and status.
	always_comb begin
		cmd = dltq_pkg::DC_NOP;
		unique case (state_q)
			S_IDLE: if (start) cmd = dltq_pkg::DC_LOAD;
			S_DISPATCH: begin
				if (op_q == dltq_pkg::OP_TICK) cmd = dltq_pkg::DC_TICK_DEC;
				else cmd = dltq_pkg::DC_WALK_INIT;
			end
			S_RM_WALK, S_RG_WALK: begin
				if (stat.walk_hit) cmd = dltq_pkg::DC_UNLINK;
				else if (!stat.walk_end) cmd = dltq_pkg::DC_WALK_STEP;
				else if (state_q == S_RG_WALK) cmd = dltq_pkg::DC_SET_PERIOD;
			end
			S_RG_PER: cmd = (op_q == dltq_pkg::OP_REM) ? dltq_pkg::DC_CLR_PERIOD
				: dltq_pkg::DC_SET_PERIOD;
			S_RG_INIT: cmd = dltq_pkg::DC_INS_INIT;
			S_INS: cmd = (stat.ins_here || stat.walk_end) ? dltq_pkg::DC_INS_PLACE
				: dltq_pkg::DC_INS_STEP;
			S_TK_CHECK: if (stat.head_due && fired_q < 5'd16) begin
				cmd = stat.pop_periodic ? dltq_pkg::DC_REINS_INIT : dltq_pkg::DC_POP;
			end
			S_TK_POP: cmd = dltq_pkg::DC_POP;
			S_TK_REINS: cmd = (stat.ins_here || stat.walk_end)
				? dltq_pkg::DC_INS_PLACE : dltq_pkg::DC_INS_STEP;
			S_TK_EMIT: ;
			S_DONE: ;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// Sequencer; fired slots are collected and sent once the tick has settled,
	// so every beat carries the final queue state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			kind_q <= '0;
			rslot_q <= '0;
			fired_q <= '0;
			emit_q <= '0;
			for (int i = 0; i < dltq_pkg::MAX_FIRE; i++) fire_slot_q[i] <= '0;
			result_valid <= 1'b0;
			result_kind <= '0;
			result_slot <= '0;
			last <= 1'b0;
			queue_nonempty <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= operation;
					rslot_q <= slot;
					fired_q <= '0;
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					unique case (op_q)
						dltq_pkg::OP_REG: state_q <= S_RG_WALK;
						dltq_pkg::OP_REM: state_q <= S_RM_WALK;
						dltq_pkg::OP_TICK: state_q <= S_TK_CHECK;
						default: state_q <= S_IDLE;
					endcase
				end
				S_RM_WALK: begin
					if (stat.walk_hit) begin
						kind_q <= dltq_pkg::RK_REM;
						state_q <= S_RG_PER;
						op_q <= dltq_pkg::OP_REM;
					end else if (stat.walk_end) begin
						kind_q <= dltq_pkg::RK_NF;
						state_q <= S_DONE;
					end
				end
				S_RG_WALK: begin
					if (stat.walk_hit) state_q <= S_RG_PER;
					else if (stat.walk_end) state_q <= S_RG_INIT;
				end
				S_RG_PER: begin
					if (op_q == dltq_pkg::OP_REM) state_q <= S_DONE;
					else state_q <= S_RG_INIT;
				end
				S_RG_INIT: state_q <= S_INS;
				S_INS: if (stat.ins_here || stat.walk_end) begin
					kind_q <= dltq_pkg::RK_REG;
					state_q <= S_DONE;
				end
				S_TK_CHECK: begin
					if (stat.head_due && fired_q < 5'd16) begin
						fire_slot_q[fired_q[dltq_pkg::SW-1:0]] <= stat.pop_slot;
						fired_q <= fired_q + 5'd1;
						state_q <= stat.pop_periodic ? S_TK_POP : S_TK_CHECK;
					end else begin
						emit_q <= '0;
						state_q <= (fired_q == 5'd0) ? S_IDLE : S_TK_EMIT;
					end
				end
				S_TK_POP: state_q <= S_TK_REINS;
				S_TK_REINS: if (stat.ins_here || stat.walk_end) state_q <= S_TK_CHECK;
				S_TK_EMIT: begin
					result_valid <= 1'b1;
					result_kind <= dltq_pkg::RK_FIRE;
					result_slot <= fire_slot_q[emit_q[dltq_pkg::SW-1:0]];
					last <= (emit_q + 5'd1 == fired_q);
					queue_nonempty <= !stat.head_nil;
					emit_q <= emit_q + 5'd1;
					if (emit_q + 5'd1 == fired_q) state_q <= S_IDLE;
				end
				S_DONE: begin
					result_valid <= 1'b1;
					result_kind <= kind_q;
					result_slot <= rslot_q;
					last <= 1'b1;
					queue_nonempty <= !stat.head_nil;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DLTQ_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, (state_q == S_IDLE) && start, busy)
	`DLTQ_ASSERT_ALWAYS(a_fire_bound, clk, arst_n, fired_q <= 5'd16)
	`DLTQ_ASSERT_NEXT(a_done_reports, clk, arst_n, state_q == S_DONE, result_valid && last)

endmodule

// ===== hdl/delta_list_timer_queue_unit.sv =====
// Delta-list alarm queue of sixteen slots. Pulse start while busy is low to
// hand in one operation; results come out one per strobe cycle on
// result_valid, and the receiver cannot stall them. Register and remove walk
// the linked list once, entry by entry, to find the slot; register then
// walks it again to place the slot, and its result is valid in the same cycle
// that busy drops. A tick lowers a nonzero delta at the head, then pops each
// due alarm in turn and walks the list again to place each periodic alarm
// anew; its fired results then come out back to back, one beat per cycle,
// after the list has settled. How long busy stays high is set by the walks
// through the linked list in the datapath.
module delta_list_timer_queue_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] operation,
	input  logic [3:0] slot,
	input  logic [31:0] time_value,
	input  logic periodic,
	output logic result_valid,
	output logic [1:0] result_kind,
	output logic [3:0] result_slot,
	output logic last,
	output logic queue_nonempty
);

	dltq_pkg::dcmd_t cmd;
	dltq_pkg::dstat_t stat;

	dltq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_slot(slot),
		.in_time(time_value), .in_periodic(periodic), .stat(stat)
	);

	dltq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.slot(slot), .stat(stat), .cmd(cmd), .busy(busy),
		.result_valid(result_valid), .result_kind(result_kind),
		.result_slot(result_slot), .last(last), .queue_nonempty(queue_nonempty)
	);

endmodule
